// ----- hdl/gcib_pkg.sv -----
// Package with widths, stage count and arctangent table of the bearing pipeline.
package gcib_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES = 30;
	localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
	localparam int RW = 32;
	localparam int VW = 35;
	localparam int LAT = 2 * NS + 6;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic signed [RW-1:0] INV_GAIN_Q30 = 32'sd652032874;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/gcib_rot_cell.sv -----
// One CORDIC rotation cell: a single micro-rotation toward zero residual angle.
module gcib_rot_cell import gcib_pkg::*; (
	input  logic                 clk,
	input  logic [4:0]           idx,
	input  logic signed [RW-1:0] x_in,
	input  logic signed [RW-1:0] y_in,
	input  logic signed [RW-1:0] z_in,
	output logic signed [RW-1:0] x_q,
	output logic signed [RW-1:0] y_q,
	output logic signed [RW-1:0] z_q
);

	logic signed [RW-1:0] xs, ys, at;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;
	assign at = signed'(atan_entry(idx));

	always_ff @(posedge clk) begin
		if (!z_in[RW-1]) begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - at;
		end else begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + at;
		end
	end

endmodule

// ----- hdl/gcib_vec_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation toward zero y.
module gcib_vec_cell import gcib_pkg::*; (
	input  logic                 clk,
	input  logic [4:0]           idx,
	input  logic signed [VW-1:0] x_in,
	input  logic signed [VW-1:0] y_in,
	input  logic [31:0]          z_in,
	output logic signed [VW-1:0] x_q,
	output logic signed [VW-1:0] y_q,
	output logic [31:0]          z_q
);

	logic signed [VW-1:0] xs, ys;

	assign xs = x_in >>> idx;
	assign ys = y_in >>> idx;

	always_ff @(posedge clk) begin
		if (!y_in[VW-1]) begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + atan_entry(idx);
		end else begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - atan_entry(idx);
		end
	end

endmodule

// ----- hdl/great_circle_initial_bearing.sv -----
// Top level of the great-circle initial bearing pipeline.
// One transfer is accepted in every cycle; busy is always low.
// The data path is built from the rotation and vectoring cell chains, one cell per stage.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Reset clears all valid flags; the data path has no reset.
module great_circle_initial_bearing import gcib_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] from_lat,
	input  logic [31:0] from_lon,
	input  logic [31:0] to_lat,
	input  logic [31:0] to_lon,
	output logic        done,
	output logic [15:0] bearing
);

	typedef struct packed {
		logic       vld;
		logic       coin;
		logic [2:0] flip;
	} side_t;

	logic [31:0] ang [3];
	logic [2:0] flip_w;
	logic signed [RW-1:0] rx [3][NS+1];
	logic signed [RW-1:0] ry [3][NS+1];
	logic signed [RW-1:0] rz [3][NS+1];
	side_t side_q [NS+1];

	logic vld_neg_s, coin_neg_s;
	logic signed [RW-1:0] sfl_s, cfl_s, stl_s, ctl_s, sdl_s, cdl_s;
	logic vld_m1_s, coin_m1_s;
	logic signed [RW-1:0] yv_m1_s, p1_m1_s, p2_m1_s, cdl_m1_s;
	logic vld_m2_s, coin_m2_s;
	logic signed [RW-1:0] yv_m2_s;
	logic signed [RW:0] xv_m2_s;
	logic signed [2*RW-1:0] prod_y, prod_1, prod_2, prod_3;
	logic signed [RW:0] p3_ext, p1_ext;

	logic signed [VW-1:0] vx [NS+1];
	logic signed [VW-1:0] vy [NS+1];
	logic [31:0] vz [NS+1];
	logic [NS:0] vvld_q, vzero_q;
	logic signed [VW-1:0] xv_ext, yv_ext;

	logic [31:0] rnd;

	assign busy = 1'b0;

	assign ang[0] = from_lat;
	assign ang[1] = to_lat;
	assign ang[2] = to_lon - from_lon;

	genvar l, s;
	generate
		for (l = 0; l < 3; l++) begin : g_fold
			logic [31:0] sum;
			assign sum = ang[l] + QUARTER_TURN;
			assign flip_w[l] = sum[31];
			always_ff @(posedge clk) begin
				rx[l][0] <= INV_GAIN_Q30;
				ry[l][0] <= '0;
				rz[l][0] <= signed'(flip_w[l] ? ang[l] + HALF_TURN : ang[l]);
			end
			for (s = 0; s < NS; s++) begin : g_rot
				gcib_rot_cell u_cell (
					.clk  (clk),
					.idx  (5'(s)),
					.x_in (rx[l][s]),
					.y_in (ry[l][s]),
					.z_in (rz[l][s]),
					.x_q  (rx[l][s+1]),
					.y_q  (ry[l][s+1]),
					.z_q  (rz[l][s+1])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) side_q[i] <= '0;
		end else begin
			side_q[0].vld <= start;
			side_q[0].coin <= (from_lat == to_lat) && (from_lon == to_lon);
			side_q[0].flip <= flip_w;
			for (int i = 1; i <= NS; i++) side_q[i] <= side_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		sfl_s <= side_q[NS].flip[0] ? -ry[0][NS] : ry[0][NS];
		cfl_s <= side_q[NS].flip[0] ? -rx[0][NS] : rx[0][NS];
		stl_s <= side_q[NS].flip[1] ? -ry[1][NS] : ry[1][NS];
		ctl_s <= side_q[NS].flip[1] ? -rx[1][NS] : rx[1][NS];
		sdl_s <= side_q[NS].flip[2] ? -ry[2][NS] : ry[2][NS];
		cdl_s <= side_q[NS].flip[2] ? -rx[2][NS] : rx[2][NS];
	end

	assign prod_y = sdl_s * ctl_s;
	assign prod_1 = cfl_s * stl_s;
	assign prod_2 = sfl_s * ctl_s;
	assign prod_3 = p2_m1_s * cdl_m1_s;
	assign p3_ext = (RW+1)'(prod_3 >>> 30);
	assign p1_ext = (RW+1)'(p1_m1_s);

	always_ff @(posedge clk) begin
		yv_m1_s <= RW'(prod_y >>> 30);
		p1_m1_s <= RW'(prod_1 >>> 30);
		p2_m1_s <= RW'(prod_2 >>> 30);
		cdl_m1_s <= cdl_s;
		yv_m2_s <= yv_m1_s;
		xv_m2_s <= p1_ext - p3_ext;
	end

	assign xv_ext = VW'(xv_m2_s);
	assign yv_ext = VW'(yv_m2_s);

	always_ff @(posedge clk) begin
		if (xv_m2_s[RW]) begin
			vx[0] <= -xv_ext;
			vy[0] <= -yv_ext;
			vz[0] <= HALF_TURN;
		end else begin
			vx[0] <= xv_ext;
			vy[0] <= yv_ext;
			vz[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_neg_s <= 1'b0;
			coin_neg_s <= 1'b0;
			vld_m1_s <= 1'b0;
			coin_m1_s <= 1'b0;
			vld_m2_s <= 1'b0;
			coin_m2_s <= 1'b0;
			vvld_q <= '0;
			vzero_q <= '0;
		end else begin
			vld_neg_s <= side_q[NS].vld;
			coin_neg_s <= side_q[NS].coin;
			vld_m1_s <= vld_neg_s;
			coin_m1_s <= coin_neg_s;
			vld_m2_s <= vld_m1_s;
			coin_m2_s <= coin_m1_s;
			vvld_q <= {vvld_q[NS-1:0], vld_m2_s};
			vzero_q <= {vzero_q[NS-1:0],
				coin_m2_s || ((xv_m2_s == '0) && (yv_m2_s == '0))};
		end
	end

	generate
		for (s = 0; s < NS; s++) begin : g_vec
			gcib_vec_cell u_cell (
				.clk  (clk),
				.idx  (5'(s)),
				.x_in (vx[s]),
				.y_in (vy[s]),
				.z_in (vz[s]),
				.x_q  (vx[s+1]),
				.y_q  (vy[s+1]),
				.z_q  (vz[s+1])
			);
		end
	endgenerate

	assign rnd = vz[NS] + 32'h0000_8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vvld_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		bearing <= vzero_q[NS] ? 16'h0000 : rnd[31:16];
	end

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("result missing after accepted transfer");
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT)) else $error("result without accepted transfer");
	a_coincident_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && from_lat == to_lat && from_lon == to_lon) |-> ##LAT (bearing == 16'h0000))
		else $error("coincident points gave nonzero bearing");
`endif

endmodule
